/* hw/rtl/plfs_pkg.sv */
package plfs_pkg;

    localparam int SUM_WIDTH_DEF = 32;

    localparam int POS_W    = 12;
    localparam int SENSOR_W = 10;
    localparam int SPEED_W  = 8;
    localparam int ERR_W    = 12;
    localparam int DERIV_W  = 13;
    localparam int REM_W    = 14;

    localparam logic [POS_W-1:0] CENTRE_POS = 12'd2000;
    localparam logic [POS_W-1:0] MAX_POS    = 12'd4000;

    // integral is kept as quotient and remainder of this divisor
    localparam int SUM_DIV = 10000;

    // error/20 as (|error| * 3277) >> 16, exact for |error| <= 2000
    localparam logic [11:0] RECIP20       = 12'd3277;
    localparam int          RECIP20_SHIFT = 16;

    localparam logic [SPEED_W-1:0]  MAX_SPEED_RST   = 8'd60;
    localparam logic [SENSOR_W-1:0] DEAD_END_TH_RST = 10'd100;
    localparam logic [SENSOR_W-1:0] BRANCH_TH_RST   = 10'd200;

    typedef enum logic [1:0] {
        CFG_MAX_SPEED   = 2'd0,
        CFG_DEAD_END_TH = 2'd1,
        CFG_BRANCH_TH   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEG_FOLLOW   = 2'd0,
        SEG_DEAD_END = 2'd1,
        SEG_BRANCH   = 2'd2
    } seg_end_t;

    typedef struct packed {
        logic [SPEED_W-1:0]  max_speed;
        logic [SENSOR_W-1:0] dead_end_th;
        logic [SENSOR_W-1:0] branch_th;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [SENSOR_W-1:0] sensor_far_left;
        logic [SENSOR_W-1:0] sensor_left;
        logic [SENSOR_W-1:0] sensor_centre;
        logic [SENSOR_W-1:0] sensor_right;
        logic [SENSOR_W-1:0] sensor_far_right;
    } sample_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DERIV_W-1:0] deriv;
        logic                      rem_nz;
        seg_end_t                  seg_end;
    } integ_t;

endpackage

/* hw/rtl/plfs_integ.sv */
module plfs_integ
    import plfs_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF,
    localparam int QW = SUM_WIDTH - 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  sample_t              sample,
    input  cfg_t                 cfg,
    output integ_t               integ,
    output logic signed [QW-1:0] quot
);

    localparam logic [64:0] HALF    = 65'd1 << (SUM_WIDTH - 1);
    localparam logic [64:0] DIV65   = 65'(SUM_DIV);
    localparam logic [64:0] QHI_U   = (HALF - 65'd1) / DIV65;
    localparam logic [64:0] RHI_U   = (HALF - 65'd1) % DIV65;
    localparam logic [64:0] QLO_MAG = (HALF + DIV65 - 65'd1) / DIV65;
    localparam logic [64:0] RLO_U   = QLO_MAG * DIV65 - HALF;

    localparam logic signed [QW-1:0] QHI = QW'(QHI_U);
    localparam logic signed [QW-1:0] QLO = QW'(65'd0 - QLO_MAG);
    localparam logic [REM_W-1:0]     RHI = REM_W'(RHI_U);
    localparam logic [REM_W-1:0]     RLO = REM_W'(RLO_U);
    localparam logic signed [15:0]   DIV16 = 16'(SUM_DIV);

    logic signed [ERR_W-1:0] prev_err_reg, prev_err_next;
    logic signed [QW-1:0]    quot_reg, quot_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    integ_t                  integ_reg, integ_next;

    logic [POS_W-1:0]        pos_c;
    logic signed [ERR_W-1:0] err;
    logic signed [15:0]      rsum;
    logic signed [QW-1:0]    q1, q_sat;
    logic [REM_W-1:0]        r1, r_sat;
    logic                    dead_end, branch;
    seg_end_t                seg_end;

    always_comb begin
        pos_c = (sample.position > MAX_POS) ? MAX_POS : sample.position;
        err   = $signed(pos_c - CENTRE_POS);

        // floor divmod form: sum = quot*SUM_DIV + rem, 0 <= rem < SUM_DIV
        rsum = $signed({2'b00, rem_reg}) + 16'(err);
        if (rsum < 16'sd0) begin
            q1 = quot_reg - QW'(1);
            r1 = REM_W'(rsum + DIV16);
        end else if (rsum >= DIV16) begin
            q1 = quot_reg + QW'(1);
            r1 = REM_W'(rsum - DIV16);
        end else begin
            q1 = quot_reg;
            r1 = rsum[REM_W-1:0];
        end

        // saturate at the signed limits of the running sum
        priority if (q1 > QHI || (q1 == QHI && r1 > RHI)) begin
            q_sat = QHI;
            r_sat = RHI;
        end else if (q1 < QLO || (q1 == QLO && r1 < RLO)) begin
            q_sat = QLO;
            r_sat = RLO;
        end else begin
            q_sat = q1;
            r_sat = r1;
        end

        dead_end = (sample.sensor_left < cfg.dead_end_th) &&
                   (sample.sensor_centre < cfg.dead_end_th) &&
                   (sample.sensor_right < cfg.dead_end_th);
        branch   = (sample.sensor_far_left > cfg.branch_th) ||
                   (sample.sensor_far_right > cfg.branch_th);
        priority if (dead_end) begin
            seg_end = SEG_DEAD_END;
        end else if (branch) begin
            seg_end = SEG_BRANCH;
        end else begin
            seg_end = SEG_FOLLOW;
        end

        integ_next.err     = err;
        integ_next.deriv   = DERIV_W'(err) - DERIV_W'(prev_err_reg);
        integ_next.rem_nz  = (r_sat != '0);
        integ_next.seg_end = seg_end;

        // a segment end restarts the controller for the next sample
        if (seg_end != SEG_FOLLOW) begin
            prev_err_next = '0;
            quot_next     = '0;
            rem_next      = '0;
        end else begin
            prev_err_next = err;
            quot_next     = q_sat;
            rem_next      = r_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            quot_reg     <= '0;
            rem_reg      <= '0;
        end else if (load) begin
            prev_err_reg <= prev_err_next;
            quot_reg     <= quot_next;
            rem_reg      <= rem_next;
        end
    end

    logic signed [QW-1:0] quot_out_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            integ_reg    <= integ_next;
            quot_out_reg <= q_sat;
        end
    end

    assign integ = integ_reg;
    assign quot  = quot_out_reg;

endmodule

/* hw/rtl/plfs_steer.sv */
module plfs_steer
    import plfs_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF,
    localparam int QW = SUM_WIDTH - 12
) (
    input  logic                 aclk,
    input  logic                 load_sum,
    input  logic                 load_out,
    input  integ_t               integ,
    input  logic signed [QW-1:0] quot,
    input  logic [SPEED_W-1:0]   max_speed,
    output logic [SPEED_W-1:0]   left_drive,
    output logic [SPEED_W-1:0]   right_drive,
    output seg_end_t             segment_end
);

    localparam int STW = QW + 4;

    logic signed [STW-1:0] steer_reg, steer_next;
    seg_end_t              seg_sum_reg;
    logic [SPEED_W-1:0]    left_reg, left_next;
    logic [SPEED_W-1:0]    right_reg, right_next;
    seg_end_t              seg_out_reg;

    logic signed [QW-1:0]  quot_trunc;
    logic [ERR_W-2:0]      err_mag;
    logic [22:0]           err_prod;
    logic [6:0]            q20;
    logic signed [STW-1:0] term20;
    logic [DERIV_W-2:0]    d_mag;
    logic [DERIV_W:0]      d3;
    logic signed [STW-1:0] termd;

    always_comb begin
        // floor quotient to truncation toward zero
        quot_trunc = quot + QW'(quot < 0 && integ.rem_nz);

        err_mag  = integ.err[ERR_W-1] ? (ERR_W-1)'(-integ.err) : integ.err[ERR_W-2:0];
        err_prod = 23'(err_mag) * 23'(RECIP20);
        q20      = err_prod[22:RECIP20_SHIFT];
        term20   = integ.err[ERR_W-1] ? -STW'(q20) : STW'(q20);

        d_mag = integ.deriv[DERIV_W-1] ? (DERIV_W-1)'(-integ.deriv)
                                        : integ.deriv[DERIV_W-2:0];
        d3    = (DERIV_W+1)'(d_mag) * (DERIV_W+1)'(3);
        termd = integ.deriv[DERIV_W-1] ? -STW'(d3 >> 1) : STW'(d3 >> 1);

        steer_next = STW'(quot_trunc) + term20 + termd;
    end

    always_ff @(posedge aclk) begin
        if (load_sum) begin
            steer_reg   <= steer_next;
            seg_sum_reg <= integ.seg_end;
        end
    end

    logic signed [STW-1:0] lim;
    logic signed [STW-1:0] steer_c;

    always_comb begin
        lim = $signed(STW'(max_speed));
        priority if (steer_reg > lim) begin
            steer_c = lim;
        end else if (steer_reg < -lim) begin
            steer_c = -lim;
        end else begin
            steer_c = steer_reg;
        end

        if (steer_c < 0) begin
            left_next  = SPEED_W'(lim + steer_c);
            right_next = max_speed;
        end else begin
            left_next  = max_speed;
            right_next = SPEED_W'(lim - steer_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            left_reg    <= left_next;
            right_reg   <= right_next;
            seg_out_reg <= seg_sum_reg;
        end
    end

    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign segment_end = seg_out_reg;

endmodule

/* hw/rtl/pid_line_follow_steer.sv */
// Channel | Direction | Handshake                   | Fields (tdata, lowest bit first)
// s_      | in        | s_tvalid / s_tready         | position, five sensor levels
// m_      | out       | m_tvalid / m_tready         | left_drive, right_drive, segment_end
// cfg_    | in        | cfg_wr_en                   | cfg_index, cfg_wdata
//
// One sample per cycle sustained while m_tready is high; an accepted sample passes the input
// register, then the integral update, steering sum, clamp and mix registers to m_tvalid.
// The integral is held as quotient and remainder of 10000, updated in the integral stage.
// Each stage holds while the one after it is full and stalled; s_tready falls only when
// all four stages are occupied and m_tready is low.
// aresetn clears stage valids and the controller state and sets the configuration registers to their defaults.
module pid_line_follow_steer
    import plfs_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // position[11:0], sensor_far_left[21:12], sensor_left[31:22], sensor_centre[41:32],
    // sensor_right[51:42], sensor_far_right[61:52], zero[63:62]
    input  logic [63:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // left_drive[7:0], right_drive[15:8], segment_end[17:16], zero[23:18]
    output logic [23:0] m_tdata,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);

    localparam int QW = SUM_WIDTH - 12;

    cfg_t    cfg_reg;
    sample_t sample_reg;
    logic    v0_reg, v1_reg, v2_reg, v3_reg;
    logic    rdy0, rdy1, rdy2, rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_speed   <= MAX_SPEED_RST;
            cfg_reg.dead_end_th <= DEAD_END_TH_RST;
            cfg_reg.branch_th   <= BRANCH_TH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAX_SPEED:   cfg_reg.max_speed   <= cfg_wdata[SPEED_W-1:0];
                CFG_DEAD_END_TH: cfg_reg.dead_end_th <= cfg_wdata;
                CFG_BRANCH_TH:   cfg_reg.branch_th   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage takes a new word when empty or when its word moves on
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;
    assign m_tvalid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && rdy0) begin
            sample_reg.position         <= s_tdata[11:0];
            sample_reg.sensor_far_left  <= s_tdata[21:12];
            sample_reg.sensor_left      <= s_tdata[31:22];
            sample_reg.sensor_centre    <= s_tdata[41:32];
            sample_reg.sensor_right     <= s_tdata[51:42];
            sample_reg.sensor_far_right <= s_tdata[61:52];
        end
    end

    integ_t               integ;
    logic signed [QW-1:0] quot;
    logic [SPEED_W-1:0]   left_drive, right_drive;
    seg_end_t             segment_end;

    plfs_integ #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_integ (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (v0_reg && rdy1),
        .sample  (sample_reg),
        .cfg     (cfg_reg),
        .integ   (integ),
        .quot    (quot)
    );

    plfs_steer #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_steer (
        .aclk        (aclk),
        .load_sum    (v1_reg && rdy2),
        .load_out    (v2_reg && rdy3),
        .integ       (integ),
        .quot        (quot),
        .max_speed   (cfg_reg.max_speed),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .segment_end (segment_end)
    );

    assign m_tdata = {6'b0, segment_end, right_drive, left_drive};

`ifndef NO_ASSERTIONS
    a_drive_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (left_drive <= cfg_reg.max_speed && right_drive <= cfg_reg.max_speed))
        else $error("drive above max speed");

    a_one_side_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (left_drive == cfg_reg.max_speed || right_drive == cfg_reg.max_speed))
        else $error("neither drive at max speed");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v0_reg && v1_reg && v2_reg && v3_reg && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline full and stalled");

    a_bubble_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v0_reg || !v1_reg || !v2_reg || !v3_reg) |-> s_tready)
        else $error("input stalled with an empty stage");
`endif

endmodule
